/* hw/rtl/dmfp_pkg.sv */
// Shared types, codes and helpers of the DNS message field parser.
`default_nettype none

package dmfp_pkg;

  // Field kinds of a result word
  localparam logic [4:0] KindId         = 5'd0;
  localparam logic [4:0] KindNameByte   = 5'd6;
  localparam logic [4:0] KindNameEnd    = 5'd7;
  localparam logic [4:0] KindQtype      = 5'd8;
  localparam logic [4:0] KindQclass     = 5'd9;
  localparam logic [4:0] KindRtype      = 5'd10;
  localparam logic [4:0] KindRclass     = 5'd11;
  localparam logic [4:0] KindTtl        = 5'd12;
  localparam logic [4:0] KindRdlength   = 5'd13;
  localparam logic [4:0] KindAddr       = 5'd14;
  localparam logic [4:0] KindMxPref     = 5'd15;
  localparam logic [4:0] KindRdNameByte = 5'd16;
  localparam logic [4:0] KindRdNameEnd  = 5'd17;
  localparam logic [4:0] KindMsgEnd     = 5'd18;

  // Message end status
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusTruncated = 2'd1;
  localparam logic [1:0] StatusNameLong  = 2'd2;
  localparam logic [1:0] StatusTrailing  = 2'd3;

  // Sections; SecNone marks that no later section holds entries
  localparam logic [2:0] SecHeader   = 3'd0;
  localparam logic [2:0] SecQuestion = 3'd1;
  localparam logic [2:0] SecNone     = 3'd5;

  // Record types decoded by structure
  localparam logic [15:0] RtypeA     = 16'd1;
  localparam logic [15:0] RtypeCname = 16'd5;
  localparam logic [15:0] RtypeMx    = 16'd15;

  // Flags bits kept: QR, opcode, AA, TC, RD, RA, rcode
  localparam logic [15:0] FlagsKeep = 16'h8000 | 16'h7800 | 16'h0400 | 16'h0200 |
                                      16'h0100 | 16'h0080 | 16'h000f;

  localparam int MaxNameBytesDef = 256;
  localparam int OutDepth        = 4;
  localparam int TdataW          = 56;
  localparam int TuserW          = 6;

  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  section;
    logic [15:0] rec_idx;
    logic [31:0] value;
    logic        lstart;
    logic [1:0]  status;
    logic        last;
  } dmfp_result_t;

  // First section at or after start_sec whose count is non-zero
  function automatic logic [2:0] first_section(logic [2:0] start_sec, logic [3:0] nz);
    logic [2:0] s;
    s = SecNone;
    for (int i = 4; i >= 1; i--) begin
      if (i >= int'(start_sec) && nz[i-1]) s = 3'(i);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dmfp_parser.sv */
// Byte-wide parse state machine: one byte in, up to two result words out.
`default_nettype none

module dmfp_parser #(
  parameter int MAX_NAME_BYTES = dmfp_pkg::MaxNameBytesDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            data_i,
  input  wire logic                  eom_i,
  input  wire logic                  tcp_prefix_i,
  output dmfp_pkg::dmfp_result_t     res0_o,
  output dmfp_pkg::dmfp_result_t     res1_o,
  output logic [1:0]                 res_cnt_o
);

  localparam int NameLenW = $clog2(MAX_NAME_BYTES + 2);

  localparam logic [3:0] PhPrefix = 4'd0;
  localparam logic [3:0] PhHeader = 4'd1;
  localparam logic [3:0] PhName   = 4'd2;
  localparam logic [3:0] PhQtype  = 4'd3;
  localparam logic [3:0] PhQclass = 4'd4;
  localparam logic [3:0] PhRtype  = 4'd5;
  localparam logic [3:0] PhRclass = 4'd6;
  localparam logic [3:0] PhTtl    = 4'd7;
  localparam logic [3:0] PhRdlen  = 4'd8;
  localparam logic [3:0] PhAddr   = 4'd9;
  localparam logic [3:0] PhMxPref = 4'd10;
  localparam logic [3:0] PhRname  = 4'd11;
  localparam logic [3:0] PhSkip   = 4'd12;
  localparam logic [3:0] PhDone   = 4'd13;
  localparam logic [3:0] PhLong   = 4'd14;
  localparam logic [3:0] PhTrail  = 4'd15;

  logic [3:0]          phase_q, phase_d;
  logic [2:0]          fbc_q, fbc_d;
  logic [31:0]         acc_q, acc_d;
  logic [15:0]         counts_q [4];
  logic [15:0]         counts_d [4];
  logic [15:0]         idx_q, idx_d;
  logic [7:0]          label_q, label_d;
  logic [NameLenW-1:0] nlen_q, nlen_d;
  logic [15:0]         rtype_q, rtype_d;
  logic [15:0]         rdrem_q, rdrem_d;
  logic [1:0]          pc_q, pc_d;
  logic [2:0]          sec_q, sec_d;

  logic [2:0]          fbc_inc, take_need;
  logic                take_done, take_en;
  logic [31:0]         acc_shift;
  logic [15:0]         f16, hdr_v, sec_cnt;
  logic [16:0]         entry_next;
  logic                entry_last;
  logic [NameLenW-1:0] nlen_inc;
  logic                hdr_go, name_go, name_rdata, name_done;
  logic                do_end_entry, do_start;
  logic [2:0]          start_sec, fs;
  logic [3:0]          nz;
  logic                ev_valid;
  logic [4:0]          ev_kind;
  logic [31:0]         ev_value;
  logic                ev_lstart;
  logic [1:0]          status;
  dmfp_pkg::dmfp_result_t ev_item, end_item;

  always_comb begin
    fbc_inc    = fbc_q + 3'd1;
    take_need  = (phase_q == PhTtl || phase_q == PhAddr) ? 3'd4 : 3'd2;
    take_done  = (fbc_inc >= take_need);
    acc_shift  = {acc_q[23:0], data_i};
    f16        = acc_shift[15:0];
    sec_cnt    = counts_q[sec_q[1:0] - 2'd1];
    entry_next = {1'b0, idx_q} + 17'd1;
    entry_last = (entry_next >= {1'b0, sec_cnt});
    nlen_inc   = nlen_q + NameLenW'(1);
    take_en    = accept_i &&
                 ((phase_q == PhPrefix && !tcp_prefix_i) || phase_q == PhHeader ||
                  phase_q == PhQtype || phase_q == PhQclass || phase_q == PhRtype ||
                  phase_q == PhRclass || phase_q == PhTtl || phase_q == PhRdlen ||
                  phase_q == PhAddr || phase_q == PhMxPref);
  end

  always_comb begin
    phase_d  = phase_q;
    fbc_d    = fbc_q;
    acc_d    = acc_q;
    counts_d = counts_q;
    idx_d    = idx_q;
    label_d  = label_q;
    nlen_d   = nlen_q;
    rtype_d  = rtype_q;
    rdrem_d  = rdrem_q;
    pc_d     = pc_q;
    sec_d    = sec_q;

    hdr_go       = 1'b0;
    hdr_v        = f16;
    name_go      = 1'b0;
    name_rdata   = 1'b0;
    name_done    = 1'b0;
    do_end_entry = 1'b0;
    do_start     = 1'b0;
    start_sec    = dmfp_pkg::SecQuestion;
    fs           = dmfp_pkg::SecNone;
    nz           = '0;
    ev_valid     = 1'b0;
    ev_kind      = dmfp_pkg::KindId;
    ev_value     = '0;
    ev_lstart    = 1'b0;
    status       = dmfp_pkg::StatusOk;

    if (take_en) begin
      acc_d = acc_shift;
      fbc_d = take_done ? 3'd0 : fbc_inc;
    end

    if (accept_i) begin
      unique case (phase_q)
        PhPrefix: begin
          if (tcp_prefix_i) begin
            pc_d = pc_q + 2'd1;
            if (pc_d >= 2'd2) begin
              pc_d    = 2'd0;
              phase_d = PhHeader;
            end
          end else begin
            phase_d = PhHeader;
            hdr_go  = 1'b1;
          end
        end
        PhHeader: hdr_go = 1'b1;
        PhName: name_go = 1'b1;
        PhQtype: begin
          if (take_done) begin
            ev_valid = 1'b1;
            ev_kind  = dmfp_pkg::KindQtype;
            ev_value = 32'(f16);
            phase_d  = PhQclass;
          end
        end
        PhQclass: begin
          if (take_done) begin
            ev_valid     = 1'b1;
            ev_kind      = dmfp_pkg::KindQclass;
            ev_value     = 32'(f16);
            do_end_entry = 1'b1;
          end
        end
        PhRtype: begin
          if (take_done) begin
            rtype_d  = f16;
            ev_valid = 1'b1;
            ev_kind  = dmfp_pkg::KindRtype;
            ev_value = 32'(f16);
            phase_d  = PhRclass;
          end
        end
        PhRclass: begin
          if (take_done) begin
            ev_valid = 1'b1;
            ev_kind  = dmfp_pkg::KindRclass;
            ev_value = 32'(f16);
            phase_d  = PhTtl;
          end
        end
        PhTtl: begin
          if (take_done) begin
            ev_valid = 1'b1;
            ev_kind  = dmfp_pkg::KindTtl;
            ev_value = acc_shift;
            phase_d  = PhRdlen;
          end
        end
        PhRdlen: begin
          if (take_done) begin
            rdrem_d  = f16;
            ev_valid = 1'b1;
            ev_kind  = dmfp_pkg::KindRdlength;
            ev_value = 32'(f16);
            if (rtype_q == dmfp_pkg::RtypeA) begin
              phase_d = PhAddr;
            end else if (rtype_q == dmfp_pkg::RtypeMx) begin
              phase_d = PhMxPref;
            end else if (rtype_q == dmfp_pkg::RtypeCname) begin
              label_d = '0;
              nlen_d  = '0;
              phase_d = PhRname;
            end else if (f16 == 16'd0) begin
              do_end_entry = 1'b1;
            end else begin
              phase_d = PhSkip;
            end
          end
        end
        PhAddr: begin
          if (take_done) begin
            ev_valid     = 1'b1;
            ev_kind      = dmfp_pkg::KindAddr;
            ev_value     = acc_shift;
            do_end_entry = 1'b1;
          end
        end
        PhMxPref: begin
          if (take_done) begin
            ev_valid = 1'b1;
            ev_kind  = dmfp_pkg::KindMxPref;
            ev_value = 32'(f16);
            label_d  = '0;
            nlen_d   = '0;
            phase_d  = PhRname;
          end
        end
        PhRname: begin
          name_go    = 1'b1;
          name_rdata = 1'b1;
        end
        PhSkip: begin
          rdrem_d = rdrem_q - 16'd1;
          if (rdrem_d == 16'd0) do_end_entry = 1'b1;
        end
        PhDone: phase_d = PhTrail;
        PhLong, PhTrail: ;
        default: phase_d = PhLong;
      endcase
    end

    // Header words: id, flags, then the four section counts
    if (hdr_go && take_done) begin
      if (idx_q == 16'd1) hdr_v = f16 & dmfp_pkg::FlagsKeep;
      ev_valid = 1'b1;
      ev_kind  = idx_q[4:0];
      ev_value = 32'(hdr_v);
      if (idx_q >= 16'd2) counts_d[idx_q[1:0] - 2'd2] = hdr_v;
      if (idx_q >= 16'd5) begin
        idx_d     = '0;
        do_start  = 1'b1;
        start_sec = dmfp_pkg::SecQuestion;
      end else begin
        idx_d = idx_q + 16'd1;
      end
    end

    if (name_go) begin
      nlen_d = nlen_inc;
      if (nlen_inc > NameLenW'(MAX_NAME_BYTES)) begin
        phase_d = PhLong;
      end else if (label_q == 8'd0) begin
        ev_valid = 1'b1;
        if (data_i == 8'd0) begin
          ev_kind   = name_rdata ? dmfp_pkg::KindRdNameEnd : dmfp_pkg::KindNameEnd;
          ev_value  = 32'(nlen_inc);
          name_done = 1'b1;
        end else begin
          label_d   = data_i;
          ev_kind   = name_rdata ? dmfp_pkg::KindRdNameByte : dmfp_pkg::KindNameByte;
          ev_value  = 32'(data_i);
          ev_lstart = 1'b1;
        end
      end else begin
        label_d  = label_q - 8'd1;
        ev_valid = 1'b1;
        ev_kind  = name_rdata ? dmfp_pkg::KindRdNameByte : dmfp_pkg::KindNameByte;
        ev_value = 32'(data_i);
      end
    end

    if (name_done) begin
      if (name_rdata) begin
        do_end_entry = 1'b1;
      end else begin
        fbc_d   = 3'd0;
        phase_d = (sec_q == dmfp_pkg::SecQuestion) ? PhQtype : PhRtype;
      end
    end

    if (do_end_entry) begin
      if (entry_last) begin
        do_start  = 1'b1;
        start_sec = sec_q + 3'd1;
      end else begin
        idx_d   = entry_next[15:0];
        label_d = '0;
        nlen_d  = '0;
        phase_d = PhName;
      end
    end

    for (int i = 0; i < 4; i++) nz[i] = (counts_d[i] != 16'd0);

    // Skip sections that hold no entries
    if (do_start) begin
      fs = dmfp_pkg::first_section(start_sec, nz);
      if (fs == dmfp_pkg::SecNone) begin
        phase_d = PhDone;
      end else begin
        sec_d   = fs;
        idx_d   = '0;
        label_d = '0;
        nlen_d  = '0;
        phase_d = PhName;
      end
    end

    if (phase_d == PhDone) status = dmfp_pkg::StatusOk;
    else if (phase_d == PhLong) status = dmfp_pkg::StatusNameLong;
    else if (phase_d == PhTrail) status = dmfp_pkg::StatusTrailing;
    else status = dmfp_pkg::StatusTruncated;

    // Message end: return every parse register to its reset value
    if (accept_i && eom_i) begin
      phase_d  = PhPrefix;
      fbc_d    = '0;
      acc_d    = '0;
      counts_d = '{default: '0};
      idx_d    = '0;
      label_d  = '0;
      nlen_d   = '0;
      rtype_d  = '0;
      rdrem_d  = '0;
      pc_d     = '0;
      sec_d    = dmfp_pkg::SecHeader;
    end
  end

  always_comb begin
    ev_item.kind     = ev_kind;
    ev_item.section  = sec_q;
    ev_item.rec_idx  = idx_q;
    ev_item.value    = ev_value;
    ev_item.lstart   = ev_lstart;
    ev_item.status   = dmfp_pkg::StatusOk;
    ev_item.last     = 1'b0;

    end_item.kind    = dmfp_pkg::KindMsgEnd;
    end_item.section = dmfp_pkg::SecHeader;
    end_item.rec_idx = '0;
    end_item.value   = '0;
    end_item.lstart  = 1'b0;
    end_item.status  = status;
    end_item.last    = 1'b1;

    res0_o    = ev_valid ? ev_item : end_item;
    res1_o    = end_item;
    res_cnt_o = 2'd0;
    if (accept_i) res_cnt_o = 2'(ev_valid) + 2'(eom_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhPrefix;
      fbc_q    <= '0;
      acc_q    <= '0;
      counts_q <= '{default: '0};
      idx_q    <= '0;
      label_q  <= '0;
      nlen_q   <= '0;
      rtype_q  <= '0;
      rdrem_q  <= '0;
      pc_q     <= '0;
      sec_q    <= dmfp_pkg::SecHeader;
    end else begin
      phase_q  <= phase_d;
      fbc_q    <= fbc_d;
      acc_q    <= acc_d;
      counts_q <= counts_d;
      idx_q    <= idx_d;
      label_q  <= label_d;
      nlen_q   <= nlen_d;
      rtype_q  <= rtype_d;
      rdrem_q  <= rdrem_d;
      pc_q     <= pc_d;
      sec_q    <= sec_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dmfp_out_fifo.sv */
// Result queue: takes up to two words a cycle, hands out one.
`default_nettype none

module dmfp_out_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [1:0]             wr_cnt_i,
  input  wire dmfp_pkg::dmfp_result_t wr0_i,
  input  wire dmfp_pkg::dmfp_result_t wr1_i,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output dmfp_pkg::dmfp_result_t      item_o,
  output logic                        room_o
);

  localparam int Depth = dmfp_pkg::OutDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  dmfp_pkg::dmfp_result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  // Room for a field word and a message end word
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(wr_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(wr_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) mem_q[wr_ptr_q] <= wr0_i;
    if (wr_cnt_i == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dns_message_field_parser.sv */
// Top level of the DNS message field parser: config register, parser and result queue.
`default_nettype none

// Takes a DNS message one byte per word on the slave stream (tlast on the final byte)
// and emits one result word per parsed field, plus a message end word carrying the
// parse status. When a byte is taken, the parse state registers update on the
// accepting edge and the byte's result words land in a four-entry result queue
// at the same edge, so a new byte can be taken every cycle. The slave side stalls
// only while the queue has fewer than two free entries; a final byte that also
// completes a field gives two words, written together and handed out in turn. The
// prefix register (skip a two-byte length prefix) is written on the config channel.
module dns_message_field_parser #(
  parameter int MAX_NAME_BYTES = dmfp_pkg::MaxNameBytesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [7:0]                  s_axis_tdata_i,  // data_byte
  input  wire logic                        s_axis_tlast_i,  // end_of_message
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // section, record_index, field_value, parse_status, zero fill
  output logic [dmfp_pkg::TdataW-1:0]      m_axis_tdata_o,
  // field_kind, label_start
  output logic [dmfp_pkg::TuserW-1:0]      m_axis_tuser_o,
  output logic                             m_axis_tlast_o,  // last_of_message
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_data_i       // tcp_length_prefix
);

  logic                   tcp_prefix_q, tcp_prefix_d;
  logic                   in_accept, room;
  logic [1:0]             res_cnt;
  dmfp_pkg::dmfp_result_t res0, res1, out_item;

  assign cfg_ready_o     = 1'b1;
  assign tcp_prefix_d    = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : tcp_prefix_q;
  assign s_axis_tready_o = room;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcp_prefix_q <= 1'b0;
    end else begin
      tcp_prefix_q <= tcp_prefix_d;
    end
  end

  dmfp_parser #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .data_i       (s_axis_tdata_i),
    .eom_i        (s_axis_tlast_i),
    .tcp_prefix_i (tcp_prefix_q),
    .res0_o       (res0),
    .res1_o       (res1),
    .res_cnt_o    (res_cnt)
  );

  dmfp_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_cnt_i (res_cnt),
    .wr0_i    (res0),
    .wr1_i    (res1),
    .pop_i    (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .item_o   (out_item),
    .room_o   (room)
  );

  assign m_axis_tdata_o = {3'b000, out_item.status, out_item.value, out_item.rec_idx,
                           out_item.section};
  assign m_axis_tuser_o = {out_item.lstart, out_item.kind};
  assign m_axis_tlast_o = out_item.last;

  a_no_result_without_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |-> res_cnt == 2'd0)
    else $error("result words written without an accepted byte");

  a_last_is_msg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_item.last == (out_item.kind == dmfp_pkg::KindMsgEnd)))
    else $error("tlast does not match message end kind");

  a_status_on_end_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_item.last) |-> out_item.status == dmfp_pkg::StatusOk)
    else $error("non-zero status on a field word");

  a_eom_gives_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tlast_i) |-> res_cnt != 2'd0)
    else $error("final byte produced no message end word");

endmodule

`default_nettype wire

/* bench/dns_message_field_parser_test.sv */
// Self-checking testbench for the DNS message field parser: directed table, then random messages.

module dns_message_field_parser_test;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int NameBound    = 256;
  localparam int ItemsPerRun  = 250;
  localparam int RandomRuns   = 8;
  localparam int MaxReports   = 10;

  typedef enum logic [3:0] {
    WaitPrefix, InHeader, InName, InQtype, InQclass, InRtype, InRclass, InTtl,
    InRdLen, InAddr, InMxPref, InRdName, InSkip, ParseDone, NameLong, Trailing
  } parse_phase_e;

  // One directed byte; typed rows carry their result word written out by hand
  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          typed;
    logic [4:0]  kind;
    logic [31:0] value;
    logic [1:0]  status;
  } dir_row_t;

  logic clk_i;
  logic rst_n     = 1'b0;
  logic s_tvalid  = 1'b0;
  logic [7:0] s_tdata = '0;
  logic s_tlast   = 1'b0;
  logic m_tready  = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_data  = 1'b0;

  logic                          s_axis_tready_o;
  logic                          m_axis_tvalid_o;
  logic [dmfp_pkg::TdataW-1:0]   m_axis_tdata_o;
  logic [dmfp_pkg::TuserW-1:0]   m_axis_tuser_o;
  logic                          m_axis_tlast_o;
  logic                          cfg_ready_o;

  dns_message_field_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Parser mirror
  logic          skip_prefix = 1'b0;
  parse_phase_e  phase       = WaitPrefix;
  logic [2:0]    nbytes      = '0;
  logic [31:0]   acc         = '0;
  logic [15:0]   sec_count [4] = '{default: '0};
  logic [15:0]   entry_idx   = '0;
  logic [7:0]    label_left  = '0;
  int            name_len    = 0;
  logic [15:0]   rtype       = '0;
  logic [15:0]   rd_left     = '0;
  logic [1:0]    pre_cnt     = '0;
  logic [2:0]    cur_sec     = dmfp_pkg::SecHeader;

  dmfp_pkg::dmfp_result_t  step_words [$];
  dmfp_pkg::dmfp_result_t  pending_fields [$];
  int            bad_words   = 0;
  int            cycle_cnt   = 0;
  int            burst_left  = 0;
  logic [7:0]    message_bytes [$];

  function automatic void clear_parse();
    phase      = WaitPrefix;
    nbytes     = '0;
    acc        = '0;
    sec_count  = '{default: '0};
    entry_idx  = '0;
    label_left = '0;
    name_len   = 0;
    rtype      = '0;
    rd_left    = '0;
    pre_cnt    = '0;
    cur_sec    = dmfp_pkg::SecHeader;
  endfunction

  function automatic void emit_field(input logic [4:0] kind, input logic [31:0] value,
                                     input logic ls);
    dmfp_pkg::dmfp_result_t w;
    w         = '0;
    w.kind    = kind;
    w.section = cur_sec;
    w.rec_idx = entry_idx;
    w.value   = value;
    w.lstart  = ls;
    step_words.push_back(w);
  endfunction

  function automatic bit take_byte(input logic [7:0] b, input int need);
    acc    = {acc[23:0], b};
    nbytes = nbytes + 3'd1;
    if (int'(nbytes) >= need) begin
      nbytes = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void start_section(input int s);
    int k;
    k = s;
    while (k <= 4 && sec_count[k-1] == 16'd0) k++;
    if (k > 4) begin
      phase = ParseDone;
    end else begin
      cur_sec    = 3'(k);
      entry_idx  = '0;
      label_left = '0;
      name_len   = 0;
      phase      = InName;
    end
  endfunction

  function automatic void end_entry();
    int nxt;
    nxt = int'(entry_idx) + 1;
    if (nxt >= int'(sec_count[2'(cur_sec - 3'd1)])) begin
      start_section(int'(cur_sec) + 1);
    end else begin
      entry_idx  = 16'(nxt);
      label_left = '0;
      name_len   = 0;
      phase      = InName;
    end
  endfunction

  // True once the terminating zero has been taken
  function automatic bit name_step(input logic [7:0] b, input bit in_rdata);
    name_len++;
    if (name_len > NameBound) begin
      phase = NameLong;
      return 1'b0;
    end
    if (label_left == 8'd0) begin
      if (b == 8'd0) begin
        emit_field(in_rdata ? dmfp_pkg::KindRdNameEnd : dmfp_pkg::KindNameEnd,
                   32'(name_len), 1'b0);
        return 1'b1;
      end
      label_left = b;
      emit_field(in_rdata ? dmfp_pkg::KindRdNameByte : dmfp_pkg::KindNameByte,
                 {24'd0, b}, 1'b1);
    end else begin
      label_left--;
      emit_field(in_rdata ? dmfp_pkg::KindRdNameByte : dmfp_pkg::KindNameByte,
                 {24'd0, b}, 1'b0);
    end
    return 1'b0;
  endfunction

  function automatic void header_step(input logic [7:0] b);
    logic [15:0] v;
    if (!take_byte(b, 2)) return;
    v = acc[15:0];
    if (entry_idx == 16'd1) v &= dmfp_pkg::FlagsKeep;
    emit_field(dmfp_pkg::KindId + 5'(entry_idx), {16'd0, v}, 1'b0);
    if (entry_idx >= 16'd2) sec_count[2'(entry_idx - 16'd2)] = v;
    if (entry_idx >= 16'd5) begin
      entry_idx = '0;
      start_section(1);
    end else begin
      entry_idx++;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eom);
    dmfp_pkg::dmfp_result_t w;
    step_words.delete();
    case (phase)
      WaitPrefix: begin
        if (skip_prefix) begin
          pre_cnt = pre_cnt + 2'd1;
          if (pre_cnt >= 2'd2) begin
            pre_cnt = '0;
            phase   = InHeader;
          end
        end else begin
          phase = InHeader;
          header_step(b);
        end
      end
      InHeader: header_step(b);
      InName: begin
        if (name_step(b, 1'b0)) begin
          nbytes = '0;
          phase  = (cur_sec == dmfp_pkg::SecQuestion) ? InQtype : InRtype;
        end
      end
      InQtype: begin
        if (take_byte(b, 2)) begin
          emit_field(dmfp_pkg::KindQtype, {16'd0, acc[15:0]}, 1'b0);
          phase = InQclass;
        end
      end
      InQclass: begin
        if (take_byte(b, 2)) begin
          emit_field(dmfp_pkg::KindQclass, {16'd0, acc[15:0]}, 1'b0);
          end_entry();
        end
      end
      InRtype: begin
        if (take_byte(b, 2)) begin
          rtype = acc[15:0];
          emit_field(dmfp_pkg::KindRtype, {16'd0, rtype}, 1'b0);
          phase = InRclass;
        end
      end
      InRclass: begin
        if (take_byte(b, 2)) begin
          emit_field(dmfp_pkg::KindRclass, {16'd0, acc[15:0]}, 1'b0);
          phase = InTtl;
        end
      end
      InTtl: begin
        if (take_byte(b, 4)) begin
          emit_field(dmfp_pkg::KindTtl, acc, 1'b0);
          phase = InRdLen;
        end
      end
      InRdLen: begin
        if (take_byte(b, 2)) begin
          rd_left = acc[15:0];
          emit_field(dmfp_pkg::KindRdlength, {16'd0, rd_left}, 1'b0);
          if (rtype == dmfp_pkg::RtypeA) begin
            phase = InAddr;
          end else if (rtype == dmfp_pkg::RtypeMx) begin
            phase = InMxPref;
          end else if (rtype == dmfp_pkg::RtypeCname) begin
            label_left = '0;
            name_len   = 0;
            phase      = InRdName;
          end else if (rd_left == 16'd0) begin
            end_entry();
          end else begin
            phase = InSkip;
          end
        end
      end
      InAddr: begin
        if (take_byte(b, 4)) begin
          emit_field(dmfp_pkg::KindAddr, acc, 1'b0);
          end_entry();
        end
      end
      InMxPref: begin
        if (take_byte(b, 2)) begin
          emit_field(dmfp_pkg::KindMxPref, {16'd0, acc[15:0]}, 1'b0);
          label_left = '0;
          name_len   = 0;
          phase      = InRdName;
        end
      end
      InRdName: begin
        if (name_step(b, 1'b1)) end_entry();
      end
      InSkip: begin
        rd_left--;
        if (rd_left == 16'd0) end_entry();
      end
      ParseDone: phase = Trailing;
      default: ;
    endcase
    if (eom) begin
      w      = '0;
      w.kind = dmfp_pkg::KindMsgEnd;
      w.last = 1'b1;
      case (phase)
        ParseDone: w.status = dmfp_pkg::StatusOk;
        NameLong:  w.status = dmfp_pkg::StatusNameLong;
        Trailing:  w.status = dmfp_pkg::StatusTrailing;
        default:   w.status = dmfp_pkg::StatusTruncated;
      endcase
      step_words.push_back(w);
      clear_parse();
    end
  endfunction

  // Present one byte, hold it until taken, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic eom, input bit typed,
                           input dmfp_pkg::dmfp_result_t typed_word);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_byte(b, eom);
    if (typed) pending_fields.push_back(typed_word);
    else foreach (step_words[i]) pending_fields.push_back(step_words[i]);
  endtask

  task automatic write_prefix(input logic v);
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    skip_prefix = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_u16(input logic [15:0] v);
    message_bytes.push_back(v[15:8]);
    message_bytes.push_back(v[7:0]);
  endfunction

  function automatic void add_label(input int len);
    message_bytes.push_back(8'(len));
    repeat (len) message_bytes.push_back(8'($urandom));
  endfunction

  // Plain short name, or one that lands exactly on the length bound
  function automatic void add_name();
    if ($urandom_range(0, 39) == 0) begin
      repeat (3) add_label(63);
      add_label(62);
    end else begin
      repeat ($urandom_range(0, 3)) add_label($urandom_range(1, 6));
    end
    message_bytes.push_back(8'd0);
  endfunction

  function automatic void build_message();
    logic [15:0] counts [4];
    logic [15:0] ty;
    int total, cut, pick, len;
    message_bytes.delete();
    if (skip_prefix) add_u16(16'($urandom));
    add_u16(16'($urandom));
    add_u16(16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick >= 83 && pick < 88) begin
      // one question whose name runs past the bound
      add_u16(16'd1);
      repeat (3) add_u16(16'd0);
      repeat (4) add_label(63);
      repeat ($urandom_range(1, 4)) message_bytes.push_back(8'($urandom));
      return;
    end
    if (pick >= 88) begin
      // noise after a valid-looking header start
      repeat ($urandom_range(1, 20)) message_bytes.push_back(8'($urandom));
      return;
    end
    foreach (counts[s]) begin
      counts[s] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
      add_u16(counts[s]);
    end
    // large counts get only a few entries, so the message ends truncated
    total = (counts[0] > 16'd3) ? 3 : int'(counts[0]);
    repeat (total) begin
      add_name();
      add_u16(16'($urandom));
      add_u16(16'($urandom));
    end
    for (int s = 1; s < 4; s++) begin
      total = (counts[s] > 16'd3) ? 3 : int'(counts[s]);
      repeat (total) begin
        add_name();
        case ($urandom_range(0, 4))
          0: ty = dmfp_pkg::RtypeA;
          1: ty = dmfp_pkg::RtypeMx;
          2: ty = dmfp_pkg::RtypeCname;
          default: ty = 16'($urandom_range(16, 65535));
        endcase
        add_u16(ty);
        add_u16(16'($urandom));
        add_u16(16'($urandom));
        add_u16(16'($urandom));
        if (ty == dmfp_pkg::RtypeA) begin
          add_u16(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd4);
          add_u16(16'($urandom));
          add_u16(16'($urandom));
        end else if (ty == dmfp_pkg::RtypeMx) begin
          add_u16(16'($urandom));
          add_u16(16'($urandom));
          add_name();
        end else if (ty == dmfp_pkg::RtypeCname) begin
          add_u16(16'($urandom));
          add_name();
        end else begin
          len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          add_u16(16'(len));
          repeat (len) message_bytes.push_back(8'($urandom));
        end
      end
    end
    if (pick >= 65 && pick < 75 && message_bytes.size() > 1) begin
      cut = $urandom_range(1, message_bytes.size() - 1);
      while (message_bytes.size() > cut) void'(message_bytes.pop_back());
    end else if (pick >= 75) begin
      repeat ($urandom_range(1, 3)) message_bytes.push_back(8'($urandom));
    end
  endfunction

  // Receiver readiness: all-ready, random and sparse patterns, rotated each cycle
  logic [31:0] stall_pat = '1;
  int          stall_age = 0;

  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pat <= '1;
        1:       stall_pat <= $urandom;
        default: stall_pat <= ($urandom & $urandom) | 32'h1;
      endcase
      stall_age <= $urandom_range(50, 300);
    end else begin
      stall_pat <= {stall_pat[30:0], stall_pat[31]};
      stall_age <= stall_age - 1;
    end
    m_tready <= stall_pat[31];
  end

  // Compare each word taken from the result stream with the oldest expectation
  always @(posedge clk_i) begin
    dmfp_pkg::dmfp_result_t got, want;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      got         = '0;
      got.kind    = m_axis_tuser_o[4:0];
      got.lstart  = m_axis_tuser_o[5];
      got.section = m_axis_tdata_o[2:0];
      got.rec_idx = m_axis_tdata_o[18:3];
      got.value   = m_axis_tdata_o[50:19];
      got.status  = m_axis_tdata_o[52:51];
      got.last    = m_axis_tlast_o;
      if (pending_fields.size() == 0) begin
        bad_words++;
        if (bad_words <= MaxReports)
          $display("unexpected word: kind %0d sec %0d idx %0d val %h ls %b st %0d last %b",
                   got.kind, got.section, got.rec_idx, got.value, got.lstart, got.status,
                   got.last);
      end else begin
        want = pending_fields.pop_front();
        if (got !== want) begin
          bad_words++;
          if (bad_words <= MaxReports)
            $display({"mismatch: want kind %0d sec %0d idx %0d val %h ls %b st %0d last %b",
                      " / got kind %0d sec %0d idx %0d val %h ls %b st %0d last %b"},
                     want.kind, want.section, want.rec_idx, want.value, want.lstart,
                     want.status, want.last, got.kind, got.section, got.rec_idx, got.value,
                     got.lstart, got.status, got.last);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  dir_row_t dir_rows [0:27] = '{
    // all-ones id and flags, zero counts: completes on the final byte
    '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'hFF, 1'b0, 1'b1, dmfp_pkg::KindId, 32'h0000FFFF, dmfp_pkg::StatusOk},
    '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b1, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    // ends halfway through the flags
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b1, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b1, 1'b1, dmfp_pkg::KindMsgEnd, 32'h0, dmfp_pkg::StatusTruncated},
    // complete header, then one byte too many
    '{8'h12, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h34, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h81, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h80, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'h00, 1'b0, 1'b0, dmfp_pkg::KindId, 32'h0, dmfp_pkg::StatusOk},
    '{8'hAB, 1'b1, 1'b1, dmfp_pkg::KindMsgEnd, 32'h0, dmfp_pkg::StatusTrailing}
  };

  initial begin : stimulus
    dmfp_pkg::dmfp_result_t w;
    int sent;
    sent = 0;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    write_prefix(1'b0);
    foreach (dir_rows[i]) begin
      w        = '0;
      w.kind   = dir_rows[i].kind;
      w.value  = dir_rows[i].value;
      w.status = dir_rows[i].status;
      w.last   = (dir_rows[i].kind == dmfp_pkg::KindMsgEnd);
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, w);
    end
    s_tvalid <= 1'b0;
    for (int run = 0; run < RandomRuns; run++) begin
      // alternate the prefix setting first, then pick it at random
      write_prefix(run < 4 ? 1'(run % 2 == 0) : 1'($urandom_range(0, 1)));
      while (sent < (run + 1) * ItemsPerRun) begin
        build_message();
        foreach (message_bytes[i])
          send_byte(message_bytes[i], i == message_bytes.size() - 1, 1'b0, '0);
        sent += message_bytes.size();
      end
      s_tvalid <= 1'b0;
    end
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (SettleCycles * 4) @(posedge clk_i);
    if (bad_words == 0 && pending_fields.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
